// ===== rtl/dtpf_pkg.sv =====
// ----------------------------------------------------------------------------
// dtpf_pkg
// Shared widths, codes and types of the drop-tail pull FIFO.
// ----------------------------------------------------------------------------
`default_nettype none

package dtpf_pkg;

	// storage depth of the descriptor memory
	localparam int DEPTH   = 64;
	localparam int PTR_W   = $clog2(DEPTH);
	localparam int CNT_W   = $clog2(DEPTH + 1);

	// field widths
	localparam int TAG_W   = 32;
	localparam int LEN_W   = 16;
	localparam int ENTRY_W = TAG_W + LEN_W;
	localparam int CAP_W   = 7;
	localparam int QLEN_W  = 7;
	localparam int DROP_W  = 32;
	localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;

	// configuration port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(64);
	localparam logic REG_CAPACITY = 1'b0;

	// item kinds
	localparam logic KIND_ARRIVAL = 1'b0;
	localparam logic KIND_REQUEST = 1'b1;

	// command queue between front and back
	localparam int CQ_DEPTH = 2;
	localparam int CQ_PTR_W = $clog2(CQ_DEPTH);
	localparam int CQ_CNT_W = $clog2(CQ_DEPTH + 1);

	// classified item
	typedef struct packed {
		logic             is_req;
		logic             is_zero;
		logic [TAG_W-1:0] tag;
		logic [LEN_W-1:0] len;
	} cmd_t;

	// result beat
	typedef struct packed {
		logic              out_valid;
		logic [TAG_W-1:0]  out_tag;
		logic [LEN_W-1:0]  out_length;
		logic              dropped;
		logic [QLEN_W-1:0] queue_length;
		logic [DROP_W-1:0] drop_total;
	} res_t;

	typedef enum logic {
		BK_IDLE,
		BK_READ
	} back_state_t;

endpackage

`default_nettype wire

// ===== rtl/dtpf_if.sv =====
// ----------------------------------------------------------------------------
// dtpf_if
// Valid/ready channels for item beats and result beats.
// ----------------------------------------------------------------------------
`default_nettype none

interface dtpf_in_if;
	logic                        valid;
	logic                        ready;
	logic                        kind;
	logic [dtpf_pkg::TAG_W-1:0]  packet_tag;
	logic [dtpf_pkg::LEN_W-1:0]  packet_length;

	modport source(output valid, kind, packet_tag, packet_length, input ready);
	modport sink(input valid, kind, packet_tag, packet_length, output ready);
endinterface

interface dtpf_out_if;
	logic                         valid;
	logic                         ready;
	logic                         out_valid;
	logic [dtpf_pkg::TAG_W-1:0]   out_tag;
	logic [dtpf_pkg::LEN_W-1:0]   out_length;
	logic                         dropped;
	logic [dtpf_pkg::QLEN_W-1:0]  queue_length;
	logic [dtpf_pkg::DROP_W-1:0]  drop_total;

	modport source(output valid, out_valid, out_tag, out_length, dropped, queue_length,
		drop_total, input ready);
	modport sink(input valid, out_valid, out_tag, out_length, dropped, queue_length,
		drop_total, output ready);
endinterface

`default_nettype wire

// ===== rtl/dtpf_front.sv =====
// ----------------------------------------------------------------------------
// dtpf_front
// Accepts item beats and classifies them into commands for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dtpf_front (
	dtpf_in_if.sink         arrive,
	input  wire logic       cq_full,
	output logic            cq_push,
	output dtpf_pkg::cmd_t  cq_cmd
);

	// take a beat whenever the command queue has room
	assign arrive.ready = !cq_full;
	assign cq_push      = arrive.valid && !cq_full;

	// classify: request or arrival, and zero-length arrivals
	always_comb begin
		cq_cmd.is_req  = (arrive.kind == dtpf_pkg::KIND_REQUEST);
		cq_cmd.is_zero = (arrive.packet_length == '0);
		cq_cmd.tag     = arrive.packet_tag;
		cq_cmd.len     = arrive.packet_length;
	end

endmodule

`default_nettype wire

// ===== rtl/dtpf_cmd_queue.sv =====
// ----------------------------------------------------------------------------
// dtpf_cmd_queue
// Short command queue that decouples the front from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dtpf_cmd_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire dtpf_pkg::cmd_t  push_cmd,
	output logic                 full,
	input  wire logic            pop,
	output logic                 cmd_valid,
	output dtpf_pkg::cmd_t       cmd
);

	dtpf_pkg::cmd_t                  slot_q [dtpf_pkg::CQ_DEPTH];
	logic [dtpf_pkg::CQ_PTR_W-1:0]   wr_ptr_q;
	logic [dtpf_pkg::CQ_PTR_W-1:0]   rd_ptr_q;
	logic [dtpf_pkg::CQ_CNT_W-1:0]   count_q;

	assign full      = (count_q == dtpf_pkg::CQ_CNT_W'(dtpf_pkg::CQ_DEPTH));
	assign cmd_valid = (count_q != '0);
	assign cmd       = slot_q[rd_ptr_q];

	// slot storage
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_cmd;
		end
	end

	// pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == dtpf_pkg::CQ_PTR_W'(dtpf_pkg::CQ_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == dtpf_pkg::CQ_PTR_W'(dtpf_pkg::CQ_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== rtl/dtpf_back.sv =====
// ----------------------------------------------------------------------------
// dtpf_back
// Executes commands against the descriptor memory and drives result beats.
// ----------------------------------------------------------------------------
`default_nettype none

module dtpf_back (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [dtpf_pkg::CAP_W-1:0]   capacity,
	input  wire logic                         cmd_valid,
	input  wire dtpf_pkg::cmd_t               cmd,
	output logic                              cmd_pop,
	dtpf_out_if.source                        result
);

	dtpf_pkg::back_state_t              state_q, state_d;

	logic [dtpf_pkg::ENTRY_W-1:0]       store_q [dtpf_pkg::DEPTH];
	logic [dtpf_pkg::ENTRY_W-1:0]       rd_data_q;

	logic [dtpf_pkg::PTR_W-1:0]         head_q, head_d;
	logic [dtpf_pkg::PTR_W-1:0]         tail_q, tail_d;
	logic [dtpf_pkg::CNT_W-1:0]         held_q, held_d;
	logic                               waiting_q, waiting_d;
	logic [dtpf_pkg::DROP_W-1:0]        discard_q, discard_d;

	dtpf_pkg::res_t                     res_q, res_d;
	logic                               res_valid_q;
	logic                               res_load;

	logic                               take;
	logic                               mem_we;
	logic                               mem_re;
	logic                               full;
	logic [dtpf_pkg::CMP_W-1:0]         eff_cap;
	logic [dtpf_pkg::DROP_W-1:0]        discard_inc;

	// effective capacity is capped at the memory depth
	always_comb begin
		eff_cap = (dtpf_pkg::CMP_W'(capacity) > dtpf_pkg::CMP_W'(dtpf_pkg::DEPTH)) ?
			dtpf_pkg::CMP_W'(dtpf_pkg::DEPTH) : dtpf_pkg::CMP_W'(capacity);
		full = (dtpf_pkg::CMP_W'(held_q) >= eff_cap);
		discard_inc = (discard_q == '1) ? discard_q : discard_q + 1'b1;
	end

	// a command retires when the result register is free or draining
	assign take    = (state_q == dtpf_pkg::BK_IDLE) && cmd_valid &&
		(!res_valid_q || result.ready);
	assign cmd_pop = take;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			dtpf_pkg::BK_IDLE: begin
				if (take && cmd.is_req && (held_q != '0)) begin
					state_d = dtpf_pkg::BK_READ;
				end
			end
			dtpf_pkg::BK_READ: begin
				state_d = dtpf_pkg::BK_IDLE;
			end
			default: begin
				state_d = dtpf_pkg::BK_IDLE;
			end
		endcase
	end

	// queue updates and result forming
	always_comb begin
		head_d    = head_q;
		tail_d    = tail_q;
		held_d    = held_q;
		waiting_d = waiting_q;
		discard_d = discard_q;
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		res_load  = 1'b0;
		res_d     = res_q;
		case (state_q)
			dtpf_pkg::BK_IDLE: begin
				if (take) begin
					if (!cmd.is_req) begin
						// arrival
						res_load           = 1'b1;
						res_d.out_valid    = 1'b0;
						res_d.out_tag      = '0;
						res_d.out_length   = '0;
						res_d.dropped      = 1'b0;
						res_d.queue_length = dtpf_pkg::QLEN_W'(held_q);
						res_d.drop_total   = discard_q;
						if (cmd.is_zero || full) begin
							res_d.dropped    = 1'b1;
							discard_d        = discard_inc;
							res_d.drop_total = discard_inc;
						end else begin
							mem_we = 1'b1;
							tail_d = (tail_q == dtpf_pkg::PTR_W'(dtpf_pkg::DEPTH - 1)) ?
								'0 : tail_q + 1'b1;
							if (waiting_q) begin
								// queue is empty while the server waits: hand it over
								res_d.out_valid  = 1'b1;
								res_d.out_tag    = cmd.tag;
								res_d.out_length = cmd.len;
								head_d = (head_q == dtpf_pkg::PTR_W'(dtpf_pkg::DEPTH - 1)) ?
									'0 : head_q + 1'b1;
								waiting_d = 1'b0;
							end else begin
								held_d = held_q + 1'b1;
							end
						end
					end else if (held_q != '0) begin
						// request with packets held: read the head
						mem_re    = 1'b1;
						head_d    = (head_q == dtpf_pkg::PTR_W'(dtpf_pkg::DEPTH - 1)) ?
							'0 : head_q + 1'b1;
						held_d    = held_q - 1'b1;
						waiting_d = 1'b0;
					end else begin
						// request on an empty queue
						res_load           = 1'b1;
						waiting_d          = 1'b1;
						res_d.out_valid    = 1'b0;
						res_d.out_tag      = '0;
						res_d.out_length   = '0;
						res_d.dropped      = 1'b0;
						res_d.queue_length = '0;
						res_d.drop_total   = discard_q;
					end
				end
			end
			dtpf_pkg::BK_READ: begin
				res_load           = 1'b1;
				res_d.out_valid    = 1'b1;
				res_d.out_tag      = rd_data_q[dtpf_pkg::ENTRY_W-1:dtpf_pkg::LEN_W];
				res_d.out_length   = rd_data_q[dtpf_pkg::LEN_W-1:0];
				res_d.dropped      = 1'b0;
				res_d.queue_length = dtpf_pkg::QLEN_W'(held_q);
				res_d.drop_total   = discard_q;
			end
			default: begin
				res_load = 1'b0;
			end
		endcase
	end

	// descriptor memory
	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_q[tail_q] <= {cmd.tag, cmd.len};
		end
		if (mem_re) begin
			rd_data_q <= store_q[head_q];
		end
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dtpf_pkg::BK_IDLE;
			head_q      <= '0;
			tail_q      <= '0;
			held_q      <= '0;
			waiting_q   <= 1'b0;
			discard_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			head_q    <= head_d;
			tail_q    <= tail_d;
			held_q    <= held_d;
			waiting_q <= waiting_d;
			discard_q <= discard_d;
			if (res_load) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (res_load) begin
			res_q <= res_d;
		end
	end

	assign result.valid        = res_valid_q;
	assign result.out_valid    = res_q.out_valid;
	assign result.out_tag      = res_q.out_tag;
	assign result.out_length   = res_q.out_length;
	assign result.dropped      = res_q.dropped;
	assign result.queue_length = res_q.queue_length;
	assign result.drop_total   = res_q.drop_total;

	// a waiting server only exists while nothing is held
	a_wait_empty: assert property (@(posedge clk) disable iff (!arst_n)
		waiting_q |-> (held_q == '0))
		else $error("server waiting while packets are held");

	// fill never exceeds the memory depth
	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		dtpf_pkg::CMP_W'(held_q) <= dtpf_pkg::CMP_W'(dtpf_pkg::DEPTH))
		else $error("fill above depth");

	// the read cycle always finds the result register free
	a_read_free: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dtpf_pkg::BK_READ) |-> !res_valid_q)
		else $error("result register busy during head read");

	// drop counter never goes down
	a_drop_mono: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (discard_q >= $past(discard_q)))
		else $error("drop counter decreased");

endmodule

`default_nettype wire

// ===== rtl/drop_tail_pull_fifo.sv =====
// ----------------------------------------------------------------------------
// drop_tail_pull_fifo
// Drop-tail packet descriptor FIFO pulled by a downstream server.
// ----------------------------------------------------------------------------
// Each item beat gives exactly one result beat. The front takes one beat per
// cycle into a two-entry command queue while it has room. The back end retires
// an arrival, or a request that finds the queue empty, from idle; a request that
// pops a held packet adds a read state for the registered descriptor memory
// read. Arrivals go at one item per cycle while result beats are accepted; a
// popping request takes no new item until its read state ends. Results leave
// through a single registered stage; while a result beat waits unaccepted the
// back end stalls and the command queue holds up to two further beats.
// Capacity (register 0, byte address 0, reset 64) is clamped to the 64-entry
// memory and should only be written while no item is in flight.
`default_nettype none

module drop_tail_pull_fifo (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	dtpf_in_if.sink                              arrive,
	dtpf_out_if.source                           result,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [dtpf_pkg::PADDR_W-1:0]    paddr,
	input  wire logic [dtpf_pkg::PDATA_W-1:0]    pwdata,
	output logic      [dtpf_pkg::PDATA_W-1:0]    prdata,
	output logic                                 pready
);

	logic [dtpf_pkg::CAP_W-1:0] capacity_q;
	logic                       cq_full;
	logic                       cq_push;
	dtpf_pkg::cmd_t             cq_in;
	logic                       cq_pop;
	logic                       cq_valid;
	dtpf_pkg::cmd_t             cq_out;

	// configuration register
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= dtpf_pkg::CAP_RESET;
		end else if (psel && penable && pwrite && (paddr[2] == dtpf_pkg::REG_CAPACITY)) begin
			capacity_q <= pwdata[dtpf_pkg::CAP_W-1:0];
		end
	end

	assign prdata = (paddr[2] == dtpf_pkg::REG_CAPACITY) ?
		dtpf_pkg::PDATA_W'(capacity_q) : '0;

	// front: accept and classify
	dtpf_front u_front (
		.arrive  (arrive),
		.cq_full (cq_full),
		.cq_push (cq_push),
		.cq_cmd  (cq_in)
	);

	// command queue
	dtpf_cmd_queue u_cmd_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (cq_push),
		.push_cmd  (cq_in),
		.full      (cq_full),
		.pop       (cq_pop),
		.cmd_valid (cq_valid),
		.cmd       (cq_out)
	);

	// back end: queue state, memory, results
	dtpf_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.capacity  (capacity_q),
		.cmd_valid (cq_valid),
		.cmd       (cq_out),
		.cmd_pop   (cq_pop),
		.result    (result)
	);

endmodule

`default_nettype wire

// ===== tb/dtpf_result_checker.sv =====
// ----------------------------------------------------------------------------
// dtpf_result_checker
// Watches the item, result and configuration channels of the drop-tail pull
// FIFO, keeps its own copy of the queue state, predicts one result beat for
// every accepted item beat and compares each result beat field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module dtpf_result_checker
	import dtpf_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	dtpf_in_if                      arrive,
	dtpf_out_if                     result,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [PADDR_W-1:0] paddr,
	input  wire logic [PDATA_W-1:0] pwdata,
	input  wire logic [PDATA_W-1:0] prdata,
	input  wire logic               pready,
	output int                      mismatches,
	output int                      pending
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [PADDR_W-1:0] CAPACITY_ADDR = PADDR_W'(4 * REG_CAPACITY);
	localparam int MAX_REPORTS = 40;

	// shadow of the queue state
	logic [ENTRY_W-1:0] shadow_store [DEPTH];
	int                 head_idx;
	int                 tail_idx;
	int                 fill;
	logic               waiting;
	logic [DROP_W-1:0]  drop_count;
	logic [CAP_W-1:0]   cap_reg;

	res_t expected_beats [$];

	// one line per mismatch, printing stops after a while but counting does not
	task automatic report_mismatch(input string what, input logic [63:0] got,
		input logic [63:0] want);
		if (mismatches < MAX_REPORTS)
			$display("[%0t] mismatch %s: got 0x%0h want 0x%0h", $realtime, what, got, want);
		mismatches++;
	endtask

	task automatic check_field(input string what, input logic [63:0] got,
		input logic [63:0] want);
		if (got !== want)
			report_mismatch(what, got, want);
	endtask

	function automatic int next_idx(input int p);
		return (p + 1 >= DEPTH) ? 0 : p + 1;
	endfunction

	// hand the head packet to the server
	task automatic pop_to_server(inout res_t r);
		r.out_valid = 1'b1;
		{r.out_tag, r.out_length} = shadow_store[head_idx];
		head_idx = next_idx(head_idx);
		fill--;
		waiting = 1'b0;
	endtask

	// advance the shadow state by one item and give the result it causes
	task automatic model_fifo_step(input logic kind, input logic [TAG_W-1:0] tag,
		input logic [LEN_W-1:0] len, output res_t r);
		int eff_cap;
		eff_cap = (int'(cap_reg) > DEPTH) ? DEPTH : int'(cap_reg);
		r = '0;
		if (kind == KIND_ARRIVAL) begin
			r.queue_length = QLEN_W'(fill);
			if (len == '0 || fill >= eff_cap) begin
				// zero length or full: discard, a waiting server keeps waiting
				r.dropped = 1'b1;
				if (drop_count != '1)
					drop_count++;
			end else begin
				shadow_store[tail_idx] = {tag, len};
				tail_idx = next_idx(tail_idx);
				fill++;
				if (waiting)
					pop_to_server(r);
			end
		end else begin
			if (fill != 0)
				pop_to_server(r);
			else
				waiting = 1'b1;
			r.queue_length = QLEN_W'(fill);
		end
		r.drop_total = drop_count;
	endtask

	// sample all channels at the rising edge
	always @(posedge clk or negedge arst_n) begin
		res_t want;
		res_t got;
		if (!arst_n) begin
			head_idx   = 0;
			tail_idx   = 0;
			fill       = 0;
			waiting    = 1'b0;
			drop_count = '0;
			cap_reg    = CAP_RESET;
			mismatches = 0;
			pending    = 0;
			expected_beats.delete();
		end else begin
			// configuration port
			if (psel && penable && pready && paddr == CAPACITY_ADDR) begin
				if (pwrite)
					cap_reg = pwdata[CAP_W-1:0];
				else
					check_field("capacity readback", prdata, PDATA_W'(cap_reg));
			end

			// item beat
			if (arrive.valid && arrive.ready) begin
				model_fifo_step(arrive.kind, arrive.packet_tag, arrive.packet_length, want);
				expected_beats.push_back(want);
			end

			// result beat
			if (result.valid && result.ready) begin
				got.out_valid    = result.out_valid;
				got.out_tag      = result.out_tag;
				got.out_length   = result.out_length;
				got.dropped      = result.dropped;
				got.queue_length = result.queue_length;
				got.drop_total   = result.drop_total;
				if (expected_beats.size() == 0) begin
					report_mismatch("unexpected result beat", 64'(got), '0);
				end else begin
					want = expected_beats.pop_front();
					check_field("out_valid", got.out_valid, want.out_valid);
					check_field("out_tag", got.out_tag, want.out_tag);
					check_field("out_length", got.out_length, want.out_length);
					check_field("dropped", got.dropped, want.dropped);
					check_field("queue_length", got.queue_length, want.queue_length);
					check_field("drop_total", got.drop_total, want.drop_total);
				end
			end

			pending = expected_beats.size();
		end
	end

endmodule

`default_nettype wire

// ===== tb/tb_drop_tail_pull_fifo.sv =====
// ----------------------------------------------------------------------------
// tb_drop_tail_pull_fifo
// Stimulus and verdict for the drop-tail pull FIFO: directed corner cases,
// then random arrival and request traffic under several capacity settings,
// with random stalls on both channels. The checker does all comparing.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_drop_tail_pull_fifo;
	import dtpf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [PADDR_W-1:0] CAPACITY_ADDR = PADDR_W'(4 * REG_CAPACITY);
	localparam int IDLE_PCT = 15;

	logic               clk;
	logic               arst_n;
	logic               psel;
	logic               penable;
	logic               pwrite;
	logic [PADDR_W-1:0] paddr;
	logic [PDATA_W-1:0] pwdata;
	logic [PDATA_W-1:0] prdata;
	logic               pready;
	logic               calm;
	int                 mismatches;
	int                 pending;

	dtpf_in_if  arrive_ch ();
	dtpf_out_if result_ch ();

	drop_tail_pull_fifo dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.arrive  (arrive_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	dtpf_result_checker checker_i (
		.clk        (clk),
		.arst_n     (arst_n),
		.arrive     (arrive_ch),
		.result     (result_ch),
		.psel       (psel),
		.penable    (penable),
		.pwrite     (pwrite),
		.paddr      (paddr),
		.pwdata     (pwdata),
		.prdata     (prdata),
		.pready     (pready),
		.mismatches (mismatches),
		.pending    (pending)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// hard stop
	initial begin
		#2_000_000;
		$display("end of test: mismatches");
		$finish;
	end

	// server side back-pressure
	initial begin
		result_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			result_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
		end
	end

	// one item beat, called and returning at a falling edge
	task automatic send_item(input logic kind, input logic [TAG_W-1:0] tag,
		input logic [LEN_W-1:0] len);
		while (!calm && $urandom_range(99) < IDLE_PCT) begin
			arrive_ch.valid <= 1'b0;
			@(negedge clk);
		end
		arrive_ch.valid         <= 1'b1;
		arrive_ch.kind          <= kind;
		arrive_ch.packet_tag    <= tag;
		arrive_ch.packet_length <= len;
		do @(posedge clk); while (!arrive_ch.ready);
		@(negedge clk);
	endtask

	// stop sending and wait until every result beat is back
	task automatic settle();
		arrive_ch.valid <= 1'b0;
		do @(negedge clk); while (pending != 0);
		repeat (4) @(negedge clk);
	endtask

	// write the capacity register and read it back, block idle
	task automatic set_capacity(input logic [PDATA_W-1:0] value);
		settle();
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= CAPACITY_ADDR;
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	// random traffic, request fields carry junk that must be ignored
	task automatic run_phase(input int n, input int arrive_pct, input int zero_pct);
		int pick;
		logic [LEN_W-1:0] len;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(99);
			if (pick < zero_pct)
				len = '0;
			else if (pick < zero_pct + 5)
				len = '1;
			else if (pick < zero_pct + 10)
				len = LEN_W'(1);
			else
				len = LEN_W'($urandom_range(65535, 1));
			if ($urandom_range(99) < arrive_pct)
				send_item(KIND_ARRIVAL, $urandom, len);
			else
				send_item(KIND_REQUEST, $urandom, len);
		end
	endtask

	initial begin
		clk                     = 1'b0;
		arst_n                  = 1'b0;
		calm                    = 1'b0;
		psel                    = 1'b0;
		penable                 = 1'b0;
		pwrite                  = 1'b0;
		paddr                   = '0;
		pwdata                  = '0;
		arrive_ch.valid         = 1'b0;
		arrive_ch.kind          = KIND_ARRIVAL;
		arrive_ch.packet_tag    = '0;
		arrive_ch.packet_length = '0;
		repeat (2) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// server waits on empty queue, a zero-length drop leaves it waiting
		send_item(KIND_REQUEST, '0, '0);
		send_item(KIND_ARRIVAL, 32'h0000_aaaa, '0);
		send_item(KIND_ARRIVAL, '1, '1);
		// plain queue and pop, extremes of tag and length
		send_item(KIND_ARRIVAL, '0, LEN_W'(1));
		send_item(KIND_ARRIVAL, 32'h1234_5678, 16'h8000);
		send_item(KIND_REQUEST, '1, '1);
		send_item(KIND_REQUEST, '0, '0);
		send_item(KIND_REQUEST, '0, '0);
		send_item(KIND_REQUEST, '0, '0);
		send_item(KIND_ARRIVAL, 32'h8000_0001, 16'h7fff);

		// capacity lowered below the fill: arrivals dropped until it drains
		for (int i = 0; i < 5; i++)
			send_item(KIND_ARRIVAL, $urandom, LEN_W'(i + 2));
		set_capacity(PDATA_W'(2));
		send_item(KIND_ARRIVAL, $urandom, 16'h0042);
		send_item(KIND_ARRIVAL, $urandom, 16'h0043);
		send_item(KIND_REQUEST, '0, '0);
		send_item(KIND_REQUEST, '0, '0);
		send_item(KIND_REQUEST, '0, '0);
		send_item(KIND_ARRIVAL, $urandom, 16'h0044);
		send_item(KIND_REQUEST, '0, '0);
		send_item(KIND_ARRIVAL, $urandom, 16'h0045);

		// zero capacity: everything dropped, a waiting server keeps waiting
		set_capacity(PDATA_W'(0));
		send_item(KIND_ARRIVAL, $urandom, 16'h0046);
		send_item(KIND_REQUEST, '0, '0);
		send_item(KIND_REQUEST, '0, '0);
		send_item(KIND_REQUEST, '0, '0);
		send_item(KIND_ARRIVAL, $urandom, 16'h0047);
		set_capacity(PDATA_W'(1));
		send_item(KIND_ARRIVAL, $urandom, 16'h0048);

		// capacity above the memory depth, no stalls so the queue fills up
		set_capacity('1);
		calm = 1'b1;
		run_phase(90, 80, 5);
		calm = 1'b0;

		set_capacity(PDATA_W'(0));
		run_phase(20, 50, 10);

		set_capacity(PDATA_W'(1));
		run_phase(50, 50, 10);

		// mostly requests at capacity 64, with one pause until all results are back
		set_capacity(PDATA_W'(64));
		run_phase(30, 30, 10);
		settle();
		run_phase(30, 30, 10);

		set_capacity($urandom);
		run_phase(80, 55, 10);

		set_capacity(PDATA_W'(5));
		run_phase(60, 55, 10);

		set_capacity(PDATA_W'(64));
		run_phase(40, 50, 10);

		settle();
		repeat (10) @(negedge clk);
		if (mismatches == 0 && pending == 0)
			$display("end of test: clean");
		else
			$display("end of test: mismatches");
		$finish;
	end

endmodule

`default_nettype wire
